/* design/cbmirq_pkg.sv */
// Package with the item codes, target codes and register addresses of the bank mapper.
package cbmirq_pkg;

    typedef enum logic [2:0] {
        FN_CPU_READ  = 3'd0,
        FN_CPU_WRITE = 3'd1,
        FN_PPU_READ  = 3'd2,
        FN_PPU_WRITE = 3'd3,
        FN_TICK      = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_PRG  = 2'd1,
        TGT_CHR  = 2'd2,
        TGT_NT   = 2'd3
    } t_target;

    localparam logic [15:0] ADDR_PRG0      = 16'h8000;
    localparam logic [15:0] ADDR_PRG1      = 16'hA000;
    localparam logic [15:0] ADDR_LAYOUT    = 16'h9000;
    localparam logic [15:0] ADDR_MIRROR    = 16'h9001;
    localparam logic [15:0] ADDR_IRQ_CTRL  = 16'h9003;
    localparam logic [15:0] ADDR_IRQ_ACK   = 16'h9004;
    localparam logic [15:0] ADDR_IRQ_HI    = 16'h9005;
    localparam logic [15:0] ADDR_IRQ_LO    = 16'h9006;
    localparam logic [15:0] ADDR_CHR_FIRST = 16'hB000;
    localparam logic [15:0] ADDR_CHR_LAST  = 16'hB007;

    localparam logic [5:0] PRG_BANK_FIXED_LO = 6'h3E;
    localparam logic [5:0] PRG_BANK_FIXED_HI = 6'h3F;

    typedef enum logic [1:0] {
        MIR_A10   = 2'd0,
        MIR_ONE_0 = 2'd1,
        MIR_A11   = 2'd2,
        MIR_ONE_1 = 2'd3
    } t_mirror;

endpackage

/* design/cartridge_bank_mapper_with_irq_core.sv */
// Cartridge bank mapper with a down-counting interrupt timer, top level.
// Each accepted item passes through the input register and then the result register,
// where its result waits until the consumer takes it. Throughput: one item per clock
// unless the consumer stalls; the input register refills while the result is taken.
// While the consumer stalls the block holds at most two items, one in each register.
// Reset (synchronous, active low) clears all bank, mode and timer registers to zero,
// sets the character ROM present flag, and empties both pipeline registers.
module cartridge_bank_mapper_with_irq_core
    import cbmirq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    // Input item channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    // Result item channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_target,
    output logic [18:0] o_mapped_address,
    output logic        o_irq_line
);

    // Configuration register.
    logic r_has_char_rom;

    // Mapper state.
    logic [5:0]  r_prog_bank [2];
    logic [7:0]  r_char_bank [8];
    logic        r_prog_layout;
    logic [1:0]  r_mirror_mode;
    logic [15:0] r_irq_reload;
    logic [15:0] r_irq_count;
    logic        r_irq_on;
    logic        r_irq_level;

    // Input register.
    logic        r_s1_valid;
    logic [2:0]  r_s1_func;
    logic [15:0] r_s1_address;
    logic [7:0]  r_s1_data;

    // Result register.
    logic        r_out_valid;
    logic [1:0]  r_target;
    logic [18:0] r_mapped_address;
    logic        r_irq_line;

    // Next-state values computed from the item in the input register.
    logic [5:0]  n_prog_bank [2];
    logic [7:0]  n_char_bank [8];
    logic        n_prog_layout;
    logic [1:0]  n_mirror_mode;
    logic [15:0] n_irq_reload;
    logic [15:0] n_irq_count;
    logic        n_irq_on;
    logic        n_irq_level;
    logic [1:0]  n_target;
    logic [18:0] n_mapped_address;

    logic        s1_advance;
    logic [13:0] ppu_addr;
    logic [10:0] nt_addr;
    logic [5:0]  prg_window;

    // The input register hands its item to the result register whenever the result
    // register is empty or its item is being taken in this cycle. The input register in
    // turn accepts a new item whenever it is empty or is emptying.
    assign s1_advance  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s1_advance;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid      = r_out_valid;
    assign o_target         = r_target;
    assign o_mapped_address = r_mapped_address;
    assign o_irq_line       = r_irq_line;

    assign ppu_addr = r_s1_address[13:0];

    // Nametable mirroring: only bit 10 of the RAM address depends on the mode.
    always_comb begin
        case (t_mirror'(r_mirror_mode))
            MIR_A10: nt_addr = {ppu_addr[10], ppu_addr[9:0]};
            MIR_A11: nt_addr = {ppu_addr[11], ppu_addr[9:0]};
            default: nt_addr = {1'b0, ppu_addr[9:0]};
        endcase
    end

    // Program window select from CPU address bits 14..13.
    always_comb begin
        case (r_s1_address[14:13])
            2'd0:    prg_window = r_prog_layout ? PRG_BANK_FIXED_LO : r_prog_bank[0];
            2'd1:    prg_window = r_prog_bank[1];
            2'd2:    prg_window = r_prog_layout ? r_prog_bank[0] : PRG_BANK_FIXED_LO;
            default: prg_window = PRG_BANK_FIXED_HI;
        endcase
    end

    // Decode of the item held in the input register. State changes take effect only
    // when the item moves on, so every item sees the state left by the one before it.
    always_comb begin
        n_prog_bank      = r_prog_bank;
        n_char_bank      = r_char_bank;
        n_prog_layout    = r_prog_layout;
        n_mirror_mode    = r_mirror_mode;
        n_irq_reload     = r_irq_reload;
        n_irq_count      = r_irq_count;
        n_irq_on         = r_irq_on;
        n_irq_level      = r_irq_level;
        n_target         = TGT_NONE;
        n_mapped_address = '0;

        case (t_func'(r_s1_func))
            FN_CPU_READ: begin
                if (r_s1_address[15]) begin
                    n_target         = TGT_PRG;
                    n_mapped_address = {prg_window, r_s1_address[12:0]};
                end
            end
            FN_CPU_WRITE: begin
                if (r_s1_address inside {[ADDR_CHR_FIRST:ADDR_CHR_LAST]}) begin
                    n_char_bank[r_s1_address[2:0]] = r_s1_data;
                end
                case (r_s1_address)
                    ADDR_PRG0:     n_prog_bank[0] = r_s1_data[5:0];
                    ADDR_PRG1:     n_prog_bank[1] = r_s1_data[5:0];
                    ADDR_LAYOUT:   n_prog_layout  = r_s1_data[7];
                    ADDR_MIRROR:   n_mirror_mode  = r_s1_data[7:6];
                    ADDR_IRQ_CTRL: begin
                        n_irq_on    = r_s1_data[7];
                        n_irq_level = 1'b0;
                    end
                    ADDR_IRQ_ACK: begin
                        n_irq_count = r_irq_reload;
                        n_irq_level = 1'b0;
                    end
                    ADDR_IRQ_HI:   n_irq_reload = {r_s1_data, r_irq_reload[7:0]};
                    ADDR_IRQ_LO:   n_irq_reload = {r_irq_reload[15:8], r_s1_data};
                    default: ;
                endcase
            end
            FN_PPU_READ: begin
                if (ppu_addr[13]) begin
                    n_target         = TGT_NT;
                    n_mapped_address = {8'd0, nt_addr};
                end else if (r_has_char_rom) begin
                    n_target         = TGT_CHR;
                    n_mapped_address = {1'b0, r_char_bank[ppu_addr[12:10]], ppu_addr[9:0]};
                end
            end
            FN_PPU_WRITE: begin
                // Pattern writes go to ROM and are dropped.
                if (ppu_addr[13]) begin
                    n_target         = TGT_NT;
                    n_mapped_address = {8'd0, nt_addr};
                end
            end
            FN_TICK: begin
                // The line rises on the tick that brings the counter from one to zero.
                if (r_irq_on && (r_irq_count != 16'd0)) begin
                    n_irq_count = r_irq_count - 16'd1;
                    if (r_irq_count == 16'd1) begin
                        n_irq_level = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_char_rom <= 1'b1;
            r_prog_bank    <= '{default: '0};
            r_char_bank    <= '{default: '0};
            r_prog_layout  <= 1'b0;
            r_mirror_mode  <= '0;
            r_irq_reload   <= '0;
            r_irq_count    <= '0;
            r_irq_on       <= 1'b0;
            r_irq_level    <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_has_char_rom <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_advance) begin
                r_prog_bank   <= n_prog_bank;
                r_char_bank   <= n_char_bank;
                r_prog_layout <= n_prog_layout;
                r_mirror_mode <= n_mirror_mode;
                r_irq_reload  <= n_irq_reload;
                r_irq_count   <= n_irq_count;
                r_irq_on      <= n_irq_on;
                r_irq_level   <= n_irq_level;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_func    <= i_func;
            r_s1_address <= i_address;
            r_s1_data    <= i_data;
        end
        if (s1_advance) begin
            r_target         <= n_target;
            r_mapped_address <= n_mapped_address;
            r_irq_line       <= n_irq_level;
        end
    end

endmodule

/* test/tb_cartridge_bank_mapper_with_irq_core.sv */
// Self-checking testbench for the cartridge bank mapper with its interrupt timer.
module tb_cartridge_bank_mapper_with_irq_core;
    import cbmirq_pkg::*;

    // One translated access as the block reports it.
    typedef struct packed {
        t_target     tgt;
        logic [18:0] maddr;
        logic        irq;
    } t_map_result;

    // Scoreboard: it mirrors the mapper registers and the timer, works out the
    // translation of every accepted item and checks the results in order.
    class mapper_scoreboard;
        bit          chr_present;
        logic [5:0]  prg_bank [2];
        logic [7:0]  chr_bank [8];
        bit          layout_swap;
        t_mirror     mirror;
        logic [15:0] timer_reload;
        logic [15:0] timer_count;
        bit          timer_on;
        bit          irq_level;
        t_map_result expected_q [$];
        int          failures;

        function new();
            chr_present  = 1'b1;
            prg_bank     = '{default: '0};
            chr_bank     = '{default: '0};
            layout_swap  = 1'b0;
            mirror       = MIR_A10;
            timer_reload = '0;
            timer_count  = '0;
            timer_on     = 1'b0;
            irq_level    = 1'b0;
            failures     = 0;
        endfunction

        function void set_char_rom(bit present);
            chr_present = present;
        endfunction

        // Applies one accepted item to the mirrored state and queues its result.
        function void note_access(t_func fn, logic [15:0] a, logic [7:0] d);
            t_map_result res;
            logic [5:0]  bank;
            res = '{tgt: TGT_NONE, maddr: '0, irq: 1'b0};
            case (fn)
                FN_CPU_READ: begin
                    if (a[15]) begin
                        // Four 8 KiB windows; the layout bit swaps the first and third.
                        case (a[14:13])
                            2'd0: bank = layout_swap ? PRG_BANK_FIXED_LO : prg_bank[0];
                            2'd1: bank = prg_bank[1];
                            2'd2: bank = layout_swap ? prg_bank[0] : PRG_BANK_FIXED_LO;
                            default: bank = PRG_BANK_FIXED_HI;
                        endcase
                        res.tgt   = TGT_PRG;
                        res.maddr = {bank, a[12:0]};
                    end
                end
                FN_CPU_WRITE: begin
                    if (a >= ADDR_CHR_FIRST && a <= ADDR_CHR_LAST) begin
                        chr_bank[a[2:0]] = d;
                    end else begin
                        case (a)
                            ADDR_PRG0:     prg_bank[0] = d[5:0];
                            ADDR_PRG1:     prg_bank[1] = d[5:0];
                            ADDR_LAYOUT:   layout_swap = d[7];
                            ADDR_MIRROR:   mirror = t_mirror'(d[7:6]);
                            ADDR_IRQ_CTRL: begin
                                timer_on  = d[7];
                                irq_level = 1'b0;
                            end
                            ADDR_IRQ_ACK: begin
                                timer_count = timer_reload;
                                irq_level   = 1'b0;
                            end
                            ADDR_IRQ_HI:   timer_reload[15:8] = d;
                            ADDR_IRQ_LO:   timer_reload[7:0] = d;
                            default: ;
                        endcase
                    end
                end
                FN_PPU_READ, FN_PPU_WRITE: begin
                    if (a[13]) begin
                        res.tgt = TGT_NT;
                        case (mirror)
                            MIR_A10: res.maddr = {8'd0, a[10], a[9:0]};
                            MIR_A11: res.maddr = {8'd0, a[11], a[9:0]};
                            default: res.maddr = {9'd0, a[9:0]};
                        endcase
                    end else if (fn == FN_PPU_READ && chr_present) begin
                        res.tgt   = TGT_CHR;
                        res.maddr = {1'b0, chr_bank[a[12:10]], a[9:0]};
                    end
                end
                FN_TICK: begin
                    if (timer_on && timer_count != 16'd0) begin
                        timer_count = timer_count - 16'd1;
                        if (timer_count == 16'd0) irq_level = 1'b1;
                    end
                end
                default: ;
            endcase
            res.irq = irq_level;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [1:0] tgt, logic [18:0] maddr, logic irq);
            t_map_result exp;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: result with nothing outstanding: target %0d addr %05h irq %0b",
                             tgt, maddr, irq);
                return;
            end
            exp = expected_q.pop_front();
            if (tgt !== exp.tgt || maddr !== exp.maddr || irq !== exp.irq) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: target %0d/%0d addr %05h/%05h irq %0b/%0b (expected/actual)",
                             exp.tgt, tgt, exp.maddr, maddr, exp.irq, irq);
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // Anything still queued at the end is a lost result.
        function void close();
            if (expected_q.size() != 0) begin
                failures += expected_q.size();
                $display("ERROR: %0d results never arrived", expected_q.size());
            end
        endfunction
    endclass

    // Cycles allowed after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_func;
    logic [15:0] i_address;
    logic [7:0]  i_data;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_target;
    logic [18:0] o_mapped_address;
    logic        o_irq_line;

    mapper_scoreboard sb = new();
    int items_sent;
    // While a calm flag is set that side does not idle at all.
    bit in_calm;
    bit out_calm;

    cartridge_bank_mapper_with_irq_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_address        (i_address),
        .i_data           (i_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_target         (o_target),
        .o_mapped_address (o_mapped_address),
        .o_irq_line       (o_irq_line)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // All inputs are driven with nonblocking assignments and the block updates
    // its registers the same way, so everything read right after a rising edge
    // holds the value from before that edge: exactly what the handshake saw.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_char_rom(i_cfg_data);
            // The item goes in before the result is checked; the result always
            // belongs to an older item, and the queue keeps the order.
            if (i_in_valid && o_in_ready) sb.note_access(t_func'(i_func), i_address, i_data);
            if (o_out_valid && i_out_ready) sb.check_result(o_target, o_mapped_address, o_irq_line);
        end
    end

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    // Presents one item and returns at the edge where it is accepted. Valid
    // stays high straight into the next item when no gap is drawn.
    task automatic send_access(t_func fn, logic [15:0] a, logic [7:0] d);
        int gap;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        gap = draw_gap(in_calm);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= fn;
        i_address  <= a;
        i_data     <= d;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Drops valid and waits until every result is back and the pipe has drained.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_char_rom(bit present);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= present;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // A timer programming sequence with a small reload value, so that the
    // following ticks actually run the counter out and raise the IRQ line.
    // Now and then the high byte is large or the timer stays disabled.
    task automatic arm_timer();
        logic [7:0] hi;
        logic [7:0] ctrl;
        int n;
        hi = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00;
        ctrl = 8'($urandom);
        ctrl[7] = ($urandom_range(0, 3) != 0);
        send_access(FN_CPU_WRITE, ADDR_IRQ_HI, hi);
        send_access(FN_CPU_WRITE, ADDR_IRQ_LO, 8'($urandom_range(0, 12)));
        send_access(FN_CPU_WRITE, ADDR_IRQ_CTRL, ctrl);
        send_access(FN_CPU_WRITE, ADDR_IRQ_ACK, 8'($urandom));
        n = $urandom_range(0, 16);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0)
                send_access(FN_PPU_READ, 16'($urandom), 8'($urandom));
            else
                send_access(FN_TICK, 16'($urandom), 8'($urandom));
        end
    endtask

    // One random item. Most CPU writes hit a real register so the bank and
    // mode settings keep changing; the rest land on random addresses.
    task automatic send_random_access();
        int pick;
        logic [15:0] a;
        logic [7:0] d;
        pick = $urandom_range(0, 99);
        a = 16'($urandom);
        d = 8'($urandom);
        if (pick < 6) begin
            arm_timer();
        end else if (pick < 30) begin
            if ($urandom_range(0, 3) != 0) a[15] = 1'b1;
            send_access(FN_CPU_READ, a, d);
        end else if (pick < 52) begin
            if ($urandom_range(0, 4) != 0) begin
                case ($urandom_range(0, 9))
                    0: a = ADDR_PRG0;
                    1: a = ADDR_PRG1;
                    2: a = ADDR_LAYOUT;
                    3: a = ADDR_MIRROR;
                    4: a = ADDR_IRQ_CTRL;
                    5: a = ADDR_IRQ_ACK;
                    6: a = ADDR_IRQ_HI;
                    7: a = ADDR_IRQ_LO;
                    default: a = ADDR_CHR_FIRST + 16'($urandom_range(0, 7));
                endcase
            end
            send_access(FN_CPU_WRITE, a, d);
        end else if (pick < 66) begin
            send_access(FN_PPU_READ, a, d);
        end else if (pick < 78) begin
            send_access(FN_PPU_WRITE, a, d);
        end else begin
            send_access(FN_TICK, a, d);
        end
    endtask

    // Result side: stalls a random number of cycles, then takes one item.
    initial begin
        int gap;
        i_out_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
            gap = draw_gap(out_calm);
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;
        i_in_valid  <= 1'b0;
        i_func      <= FN_CPU_READ;
        i_address   <= '0;
        i_data      <= '0;
        items_sent  = 0;
        in_calm     = 1'b0;
        out_calm    = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with character ROM present as after reset.
        // CPU reads below program space map to no target; the top reads the fixed bank.
        send_access(FN_CPU_READ, 16'h0000, 8'h00);
        send_access(FN_CPU_READ, 16'h7FFF, 8'hFF);
        send_access(FN_CPU_READ, 16'hFFFF, 8'h00);
        // Program banks keep only six bits; then the swapped layout.
        send_access(FN_CPU_WRITE, ADDR_PRG0, 8'hFF);
        send_access(FN_CPU_WRITE, ADDR_PRG1, 8'h2A);
        send_access(FN_CPU_READ, 16'h8000, 8'h00);
        send_access(FN_CPU_WRITE, ADDR_LAYOUT, 8'h80);
        send_access(FN_CPU_READ, 16'h9ABC, 8'h00);
        send_access(FN_CPU_READ, 16'hC001, 8'h00);
        // First and last character banks, pattern reads through both, and a
        // pattern write that must be ignored.
        send_access(FN_CPU_WRITE, ADDR_CHR_FIRST, 8'hFF);
        send_access(FN_CPU_WRITE, ADDR_CHR_LAST, 8'h5A);
        send_access(FN_PPU_READ, 16'h03FF, 8'h00);
        send_access(FN_PPU_READ, 16'hDFFF, 8'h00);
        send_access(FN_PPU_WRITE, 16'h0400, 8'hFF);
        // Nametable accesses under the A11 mirroring, upper address bits ignored.
        send_access(FN_CPU_WRITE, ADDR_MIRROR, 8'h80);
        send_access(FN_PPU_READ, 16'h2C00, 8'h00);
        send_access(FN_PPU_WRITE, 16'hFFFF, 8'h00);
        // A write that matches no register.
        send_access(FN_CPU_WRITE, 16'h9002, 8'hFF);
        // Timer: a tick on a zero counter does nothing, then a reload of two
        // runs out on the second tick, the next tick stays put, and a control
        // write drops the line again.
        send_access(FN_CPU_WRITE, ADDR_IRQ_HI, 8'h00);
        send_access(FN_CPU_WRITE, ADDR_IRQ_LO, 8'h02);
        send_access(FN_CPU_WRITE, ADDR_IRQ_CTRL, 8'h80);
        send_access(FN_TICK, 16'h0000, 8'h00);
        send_access(FN_CPU_WRITE, ADDR_IRQ_ACK, 8'h00);
        repeat (3) send_access(FN_TICK, 16'hFFFF, 8'hFF);
        send_access(FN_CPU_WRITE, ADDR_IRQ_CTRL, 8'h00);

        // Random part in three phases, toggling the character ROM between them.
        settle();
        write_char_rom(1'b1);
        while (items_sent < 370) send_random_access();
        settle();
        write_char_rom(1'b0);
        while (items_sent < 710) send_random_access();
        settle();
        write_char_rom(1'b1);
        while (items_sent < 1050) send_random_access();

        settle();
        sb.close();
        if (sb.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
